FILE: rtl/klein_bottle_surface_point_top_assert.svh
// Assertion macros used by the checker of the Klein bottle surface point block.
`ifndef KLEIN_BOTTLE_SURFACE_POINT_TOP_ASSERT_SVH
`define KLEIN_BOTTLE_SURFACE_POINT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KBSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kbsp: implication check failed");

// Implication with a fixed delay between cause and effect.
`define KBSP_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## n (cons)) \
        else $error("kbsp: delayed check failed");

`endif

FILE: rtl/kbsp_pkg.sv
// Shared constants, tables and types of the Klein bottle surface point block.
package kbsp_pkg;

    localparam int ANGLE_BITS_DEFAULT = 16;
    localparam int FRAC_BITS_DEFAULT  = 13;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 33;
    localparam int TRIG_W       = 32;
    localparam int OUT_W        = 18;

    // Input register, one register per rotation, fold register, four combine stages.
    localparam int PIPE_DEPTH = CORDIC_STEPS + 6;

    localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

    // Arctangent of 2^-i, where 2^32 is a full turn.
    localparam logic [29:0] ATAN_TABLE [CORDIC_STEPS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic [1:0]                 quad;
    } cordic_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } trig_t;

endpackage

FILE: rtl/kbsp_cordic_cell.sv
// One rotation step of the sine/cosine chain, registered.
module kbsp_cordic_cell
    import kbsp_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  cordic_t prev,
    output cordic_t cur
);

    localparam logic signed [CORDIC_W-1:0] ANGLE = CORDIC_W'(ATAN_TABLE[STEP]);

    cordic_t cur_reg;
    cordic_t cur_next;

    always_comb
    begin
        cur_next = prev;
        if (!prev.z[CORDIC_W-1])
        begin
            cur_next.x = $signed(prev.x) - ($signed(prev.y) >>> STEP);
            cur_next.y = $signed(prev.y) + ($signed(prev.x) >>> STEP);
            cur_next.z = $signed(prev.z) - ANGLE;
        end
        else
        begin
            cur_next.x = $signed(prev.x) + ($signed(prev.y) >>> STEP);
            cur_next.y = $signed(prev.y) - ($signed(prev.x) >>> STEP);
            cur_next.z = $signed(prev.z) + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign cur = cur_reg;

endmodule

FILE: rtl/kbsp_cordic_chain.sv
// Row of rotation cells plus quadrant fold: sine and cosine of one phase in Q30.
module kbsp_cordic_chain
    import kbsp_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic [ANGLE_BITS-1:0] phase,
    output trig_t                 trig
);

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    logic [31:0] phase_word;
    cordic_t     stage [CORDIC_STEPS+1];
    cordic_t     last;
    trig_t       trig_reg;
    trig_t       trig_next;

    assign phase_word = {phase, {(32-ANGLE_BITS){1'b0}}};

    // The rotation runs over the angle within its quadrant; the quadrant is folded in after.
    assign stage[0] = {CORDIC_W'(CORDIC_GAIN), {CORDIC_W{1'b0}},
                       {{(CORDIC_W-30){1'b0}}, phase_word[29:0]}, phase_word[31:30]};

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        kbsp_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk  (clk),
            .prev (stage[i]),
            .cur  (stage[i+1])
        );
    end

    assign last = stage[CORDIC_STEPS];

    always_comb
    begin
        case (last.quad)
            QUAD_FIRST:
            begin
                trig_next.c = TRIG_W'(last.x);
                trig_next.s = TRIG_W'(last.y);
            end
            QUAD_SECOND:
            begin
                trig_next.c = TRIG_W'(-last.y);
                trig_next.s = TRIG_W'(last.x);
            end
            QUAD_THIRD:
            begin
                trig_next.c = TRIG_W'(-last.x);
                trig_next.s = TRIG_W'(-last.y);
            end
            default:
            begin
                trig_next.c = TRIG_W'(last.y);
                trig_next.s = TRIG_W'(-last.x);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule

FILE: rtl/kbsp_combine.sv
// Products, rounding and saturation that turn four sine/cosine pairs into x, y and z.
module kbsp_combine
    import kbsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  trig_t                   tu,
    input  trig_t                   tu2,
    input  trig_t                   tv,
    input  trig_t                   tvh,
    output logic signed [OUT_W-1:0] x_coord,
    output logic signed [OUT_W-1:0] y_coord,
    output logic signed [OUT_W-1:0] z_coord
);

    localparam int PW = 2 * TRIG_W;
    localparam int DW = PW + 1;
    localparam int RW = 34;
    localparam int QW = RW + TRIG_W;
    localparam int SH = 60 - FRAC_BITS;

    localparam logic signed [DW-1:0] HALF_Q30 = DW'(1) << 29;
    localparam logic signed [RW-1:0] TWO_Q30  = RW'(2) << 30;
    localparam logic signed [QW:0]   HALF_OUT = (QW+1)'(1) << (SH-1);
    localparam logic signed [QW:0]   SAT_HI   = (QW+1)'((1 << (OUT_W-1)) - 1);
    localparam logic signed [QW:0]   SAT_LO   = -SAT_HI - (QW+1)'(1);

    logic signed [PW-1:0]     pa_reg;
    logic signed [PW-1:0]     pb_reg;
    logic signed [PW-1:0]     pc_reg;
    logic signed [PW-1:0]     pd_reg;
    logic signed [TRIG_W-1:0] tvc1_reg;
    logic signed [TRIG_W-1:0] tvs1_reg;

    logic signed [DW-1:0]     diff;
    logic signed [DW-1:0]     inner;
    logic signed [RW-1:0]     r_next;
    logic signed [DW-1:0]     zs_next;
    logic signed [RW-1:0]     r_reg;
    logic signed [DW-1:0]     zs_reg;
    logic signed [TRIG_W-1:0] tvc2_reg;
    logic signed [TRIG_W-1:0] tvs2_reg;

    logic signed [QW-1:0]     xq_reg;
    logic signed [QW-1:0]     yq_reg;
    logic signed [DW-1:0]     zq_reg;

    logic signed [OUT_W-1:0]  x_next;
    logic signed [OUT_W-1:0]  y_next;
    logic signed [OUT_W-1:0]  z_next;
    logic signed [OUT_W-1:0]  x_reg;
    logic signed [OUT_W-1:0]  y_reg;
    logic signed [OUT_W-1:0]  z_reg;

    // Round half up at the output scale, then clamp to the output range.
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [QW-1:0] q);
        logic signed [QW:0] sum;
        logic signed [QW:0] v;
        sum = (QW+1)'(q) + HALF_OUT;
        v   = sum >>> SH;
        if (v > SAT_HI)
        begin
            v = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            v = SAT_LO;
        end
        return v[OUT_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        pa_reg   <= tvh.c * tu.s;
        pb_reg   <= tvh.s * tu2.s;
        pc_reg   <= tvh.s * tu.s;
        pd_reg   <= tvh.c * tu2.s;
        tvc1_reg <= tv.c;
        tvs1_reg <= tv.s;
    end

    // The radius term is rounded back to Q30 and offset by two.
    always_comb
    begin
        diff    = {pa_reg[PW-1], pa_reg} - {pb_reg[PW-1], pb_reg} + HALF_Q30;
        inner   = diff >>> 30;
        r_next  = RW'(inner) + TWO_Q30;
        zs_next = {pc_reg[PW-1], pc_reg} + {pd_reg[PW-1], pd_reg};
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        zs_reg   <= zs_next;
        tvc2_reg <= tvc1_reg;
        tvs2_reg <= tvs1_reg;
    end

    always_ff @(posedge clk)
    begin
        xq_reg <= r_reg * tvc2_reg;
        yq_reg <= r_reg * tvs2_reg;
        zq_reg <= zs_reg;
    end

    always_comb
    begin
        x_next = round_sat(xq_reg);
        y_next = round_sat(yq_reg);
        z_next = round_sat(QW'(zq_reg));
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_coord = x_reg;
    assign y_coord = y_reg;
    assign z_coord = z_reg;

endmodule

FILE: rtl/klein_bottle_surface_point_top.sv
// Top level of the figure-eight Klein bottle surface point evaluator.
//
// Usage: drive u_angle and v_angle (phases, a full turn is 2^ANGLE_BITS) and raise start
// for one cycle per item. An item is taken at each rising edge where start is high and
// busy is low; busy never rises, so a new item may enter in every cycle.
// Each item yields one point: x_coord, y_coord and z_coord in signed fixed point with
// FRAC_BITS fraction bits, valid for exactly one cycle while done is high.
// Done goes high once the item has passed the input register, the 30 registered
// rotation cells of the sine/cosine chains, the quadrant fold and four product and
// rounding stages. Throughput is one item per cycle; items come out in the order
// they went in.
// Four chains run side by side for u, 2u, v and v/2; 2u wraps modulo a turn and v/2
// drops the low phase bit.
// Reset clears the item-valid pipeline, so no done pulse follows reset for items that
// were in flight. The receiver cannot stall the block; results must be taken when done
// is high.
module klein_bottle_surface_point_top
    import kbsp_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [ANGLE_BITS-1:0]   u_angle,
    input  logic [ANGLE_BITS-1:0]   v_angle,
    output logic                    done,
    output logic signed [OUT_W-1:0] x_coord,
    output logic signed [OUT_W-1:0] y_coord,
    output logic signed [OUT_W-1:0] z_coord
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [ANGLE_BITS-1:0] u_reg;
    logic [ANGLE_BITS-1:0] v_reg;
    logic [ANGLE_BITS-1:0] u2_phase;
    logic [ANGLE_BITS-1:0] vh_phase;
    trig_t                 tu;
    trig_t                 tu2;
    trig_t                 tv;
    trig_t                 tvh;

    assign busy       = 1'b0;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_angle;
        v_reg <= v_angle;
    end

    assign u2_phase = {u_reg[ANGLE_BITS-2:0], 1'b0};
    assign vh_phase = {1'b0, v_reg[ANGLE_BITS-1:1]};

    kbsp_cordic_chain #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_chain_u (
        .clk   (clk),
        .phase (u_reg),
        .trig  (tu)
    );

    kbsp_cordic_chain #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_chain_u2 (
        .clk   (clk),
        .phase (u2_phase),
        .trig  (tu2)
    );

    kbsp_cordic_chain #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_chain_v (
        .clk   (clk),
        .phase (v_reg),
        .trig  (tv)
    );

    kbsp_cordic_chain #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_chain_vh (
        .clk   (clk),
        .phase (vh_phase),
        .trig  (tvh)
    );

    kbsp_combine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_combine (
        .clk     (clk),
        .tu      (tu),
        .tu2     (tu2),
        .tv      (tv),
        .tvh     (tvh),
        .x_coord (x_coord),
        .y_coord (y_coord),
        .z_coord (z_coord)
    );

    assign done = valid_reg[PIPE_DEPTH-1];

endmodule

FILE: rtl/kbsp_checker.sv
// Port-level checker for the Klein bottle surface point block, bound to the top level.
`include "klein_bottle_surface_point_top_assert.svh"

module kbsp_checker
    import kbsp_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [ANGLE_BITS-1:0]   u_angle,
    input logic [ANGLE_BITS-1:0]   v_angle,
    input logic                    done,
    input logic signed [OUT_W-1:0] x_coord,
    input logic signed [OUT_W-1:0] y_coord,
    input logic signed [OUT_W-1:0] z_coord
);

    logic                    take;
    logic [2*ANGLE_BITS-1:0] angles;
    logic [3*OUT_W-1:0]      point;

    assign take   = start && !busy;
    assign angles = {u_angle, v_angle};
    assign point  = {x_coord, y_coord, z_coord};

    // Every result traces back to an item taken a fixed number of cycles earlier.
    `KBSP_ASSERT_IMPLY(a_done_has_item, clk, rst_n, done, $past(take, PIPE_DEPTH))

    // An item taken under reset-free operation always produces its result.
    `KBSP_ASSERT_DELAY(a_item_gives_done, clk, rst_n, take, PIPE_DEPTH, done)

    // Two equal items back to back give equal results in consecutive cycles.
    `KBSP_ASSERT_DELAY(a_same_item_same_point, clk, rst_n,
        take && $past(take) && $stable(angles), PIPE_DEPTH, $stable(point))

    // At the origin of both parameters the point lies on the x axis.
    `KBSP_ASSERT_DELAY(a_origin_on_axis, clk, rst_n, take && angles == '0, PIPE_DEPTH,
        y_coord == '0 && z_coord == '0)

endmodule

bind klein_bottle_surface_point_top kbsp_checker #(
    .ANGLE_BITS (ANGLE_BITS)
) u_kbsp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .u_angle (u_angle),
    .v_angle (v_angle),
    .done    (done),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .z_coord (z_coord)
);
